// ===== sv/pts_pkg.sv =====
// shared types and constants of the periodic task scheduler
package pts_pkg;

  localparam int MAX_OUT     = 16;
  localparam int FOUND_W     = $clog2(MAX_OUT + 1);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  typedef enum logic [1:0] {
    KIND_ADD      = 2'd0,
    KIND_DELETE   = 2'd1,
    KIND_TICK     = 2'd2,
    KIND_DISPATCH = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    RP_ADDED       = 3'd0,
    RP_FULL        = 3'd1,
    RP_DELETED     = 3'd2,
    RP_DEL_INVALID = 3'd3,
    RP_TICK_DONE   = 3'd4,
    RP_RUN_TASK    = 3'd5,
    RP_NONE_READY  = 3'd6
  } reply_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_ADD,
    BK_WALK,
    BK_DONE
  } bk_state_e;

  typedef struct packed {
    kind_e       kind;
    logic [15:0] tag;
    logic [31:0] delay;
    logic [31:0] period;
    logic [7:0]  slot;
    logic        slot_ok;
  } cmd_t;

  typedef struct packed {
    logic [15:0] tag;
    logic [31:0] delay;
    logic [31:0] period;
    logic [7:0]  runs;
  } slot_t;

endpackage

// ===== sv/pts_front.sv =====
// input side: accepts transactions, classifies them and queues commands
module pts_front #(
  parameter int NUM_SLOTS = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           s_axis_tvalid_i,
  output logic           s_axis_tready_o,
  input  logic [87:0]    s_axis_tdata_i,  // task_tag, start_delay, repeat_period, slot
  input  logic [1:0]     s_axis_tuser_i,  // kind
  output logic           q_vld_o,
  input  logic           q_rdy_i,
  output pts_pkg::cmd_t  q_cmd_o
);
  import pts_pkg::*;

  localparam logic [8:0] SLOT_LIM = 9'(NUM_SLOTS);

  cmd_t              fifo_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  cmd_t              in_cmd;
  logic              push, pop;

  always_comb begin
    in_cmd.kind    = kind_e'(s_axis_tuser_i);
    in_cmd.tag     = s_axis_tdata_i[15:0];
    in_cmd.delay   = s_axis_tdata_i[47:16];
    in_cmd.period  = s_axis_tdata_i[79:48];
    in_cmd.slot    = s_axis_tdata_i[87:80];
    in_cmd.slot_ok = ({1'b0, s_axis_tdata_i[87:80]} < SLOT_LIM);
  end

  assign s_axis_tready_o = (cnt_q != QCNT_W'(QUEUE_DEPTH));
  assign push            = s_axis_tvalid_i && s_axis_tready_o;
  assign q_vld_o         = (cnt_q != '0);
  assign pop             = q_vld_o && q_rdy_i;
  assign q_cmd_o         = fifo_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= in_cmd;
    end
  end

endmodule

// ===== sv/pts_back.sv =====
// execution side: slot table, slot walk and result register
module pts_back #(
  parameter int NUM_SLOTS = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_vld_i,
  output logic           q_rdy_o,
  input  pts_pkg::cmd_t  q_cmd_i,
  output logic           m_axis_tvalid_o,
  input  logic           m_axis_tready_i,
  output logic [23:0]    m_axis_tdata_o,  // slot_out, tag_out, zero pad
  output logic [2:0]     m_axis_tuser_o,  // reply
  output logic           m_axis_tlast_o
);
  import pts_pkg::*;

  localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CNT_W = $clog2(NUM_SLOTS + 1);

  bk_state_e            state_q, state_d;
  cmd_t                 cmd_q, cmd_d;
  logic [NUM_SLOTS-1:0] occ_q, occ_d;
  logic [CNT_W-1:0]     rd_idx_q, rd_idx_d;
  logic                 s1_vld_q, s1_vld_d;
  logic [IDX_W-1:0]     s1_idx_q, s1_idx_d;
  logic                 hold_vld_q, hold_vld_d;
  logic [IDX_W-1:0]     hold_idx_q, hold_idx_d;
  logic [15:0]          hold_tag_q, hold_tag_d;
  logic [FOUND_W-1:0]   found_q, found_d;
  reply_e               fin_reply_q, fin_reply_d;
  logic [3:0]           fin_slot_q, fin_slot_d;
  logic [15:0]          fin_tag_q, fin_tag_d;

  slot_t                mem_q [NUM_SLOTS];
  slot_t                rdata_q;
  slot_t                wdata, tick_upd;
  logic                 we, rd_en;
  logic [IDX_W-1:0]     waddr;

  logic                 out_vld_q;
  reply_e               out_reply_q;
  logic [3:0]           out_slot_q;
  logic [15:0]          out_tag_q;
  logic                 out_last_q;
  logic                 out_ld, out_last, out_free;
  reply_e               out_reply;
  logic [3:0]           out_slot;
  logic [15:0]          out_tag;

  logic                 s1_occ, hit, stall, cap;
  logic [IDX_W-1:0]     add_idx, del_idx;

  assign out_free = !out_vld_q || m_axis_tready_i;
  assign s1_occ   = s1_vld_q && occ_q[s1_idx_q];
  assign hit      = s1_occ && (cmd_q.kind == KIND_DISPATCH) && (rdata_q.runs != 8'd0);
  assign stall    = hit && hold_vld_q && !out_free;
  assign add_idx  = rd_idx_q[IDX_W-1:0];
  assign del_idx  = q_cmd_i.slot[IDX_W-1:0];

  always_comb begin
    tick_upd = rdata_q;
    if (rdata_q.delay != 32'd0) begin
      tick_upd.delay = rdata_q.delay - 32'd1;
    end else begin
      tick_upd.delay = rdata_q.period;
      if (rdata_q.runs != 8'hFF) begin
        tick_upd.runs = rdata_q.runs + 8'd1;
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    occ_d       = occ_q;
    rd_idx_d    = rd_idx_q;
    s1_vld_d    = s1_vld_q;
    s1_idx_d    = s1_idx_q;
    hold_vld_d  = hold_vld_q;
    hold_idx_d  = hold_idx_q;
    hold_tag_d  = hold_tag_q;
    found_d     = found_q;
    fin_reply_d = fin_reply_q;
    fin_slot_d  = fin_slot_q;
    fin_tag_d   = fin_tag_q;
    we          = 1'b0;
    waddr       = s1_idx_q;
    wdata       = rdata_q;
    rd_en       = 1'b0;
    q_rdy_o     = 1'b0;
    out_ld      = 1'b0;
    out_reply   = fin_reply_q;
    out_slot    = fin_slot_q;
    out_tag     = fin_tag_q;
    out_last    = 1'b1;
    cap         = 1'b0;

    case (state_q)
      BK_IDLE: begin
        q_rdy_o = 1'b1;
        if (q_vld_i) begin
          cmd_d      = q_cmd_i;
          rd_idx_d   = '0;
          s1_vld_d   = 1'b0;
          hold_vld_d = 1'b0;
          found_d    = '0;
          fin_slot_d = 4'd0;
          fin_tag_d  = 16'd0;
          case (q_cmd_i.kind)
            KIND_ADD: begin
              state_d = BK_ADD;
            end
            KIND_DELETE: begin
              if (q_cmd_i.slot_ok && occ_q[del_idx]) begin
                occ_d[del_idx] = 1'b0;
                fin_reply_d    = RP_DELETED;
                fin_slot_d     = q_cmd_i.slot[3:0];
              end else begin
                fin_reply_d = RP_DEL_INVALID;
              end
              state_d = BK_DONE;
            end
            default: begin
              state_d = BK_WALK;
            end
          endcase
        end
      end

      BK_ADD: begin
        if (!occ_q[add_idx]) begin
          we             = 1'b1;
          waddr          = add_idx;
          wdata.tag      = cmd_q.tag;
          wdata.delay    = cmd_q.delay;
          wdata.period   = cmd_q.period;
          wdata.runs     = 8'd0;
          occ_d[add_idx] = 1'b1;
          fin_reply_d    = RP_ADDED;
          fin_slot_d     = 4'(add_idx);
          state_d        = BK_DONE;
        end else if (rd_idx_q == CNT_W'(NUM_SLOTS - 1)) begin
          fin_reply_d = RP_FULL;
          state_d     = BK_DONE;
        end else begin
          rd_idx_d = rd_idx_q + 1'b1;
        end
      end

      BK_WALK: begin
        if (!stall) begin
          if (s1_occ && (cmd_q.kind == KIND_TICK)) begin
            we    = 1'b1;
            wdata = tick_upd;
          end else if (hit) begin
            we         = 1'b1;
            wdata.runs = rdata_q.runs - 8'd1;
            if (hold_vld_q) begin
              out_ld    = 1'b1;
              out_reply = RP_RUN_TASK;
              out_slot  = 4'(hold_idx_q);
              out_tag   = hold_tag_q;
              out_last  = 1'b0;
            end
            hold_vld_d = 1'b1;
            hold_idx_d = s1_idx_q;
            hold_tag_d = rdata_q.tag;
            found_d    = found_q + 1'b1;
            if (found_q == FOUND_W'(MAX_OUT - 1)) begin
              cap = 1'b1;
            end
          end
          if (cap) begin
            // run limit reached, this run closes the dispatch
            fin_reply_d = RP_RUN_TASK;
            fin_slot_d  = 4'(s1_idx_q);
            fin_tag_d   = rdata_q.tag;
            hold_vld_d  = 1'b0;
            s1_vld_d    = 1'b0;
            state_d     = BK_DONE;
          end else if (!s1_vld_q && (rd_idx_q == CNT_W'(NUM_SLOTS))) begin
            hold_vld_d = 1'b0;
            state_d    = BK_DONE;
            if (cmd_q.kind == KIND_TICK) begin
              fin_reply_d = RP_TICK_DONE;
            end else if (hold_vld_q) begin
              fin_reply_d = RP_RUN_TASK;
              fin_slot_d  = 4'(hold_idx_q);
              fin_tag_d   = hold_tag_q;
            end else begin
              fin_reply_d = RP_NONE_READY;
            end
          end else if (rd_idx_q < CNT_W'(NUM_SLOTS)) begin
            rd_en    = 1'b1;
            rd_idx_d = rd_idx_q + 1'b1;
            s1_vld_d = 1'b1;
            s1_idx_d = rd_idx_q[IDX_W-1:0];
          end else begin
            s1_vld_d = 1'b0;
          end
        end
      end

      BK_DONE: begin
        if (out_free) begin
          out_ld  = 1'b1;
          state_d = BK_IDLE;
        end
      end

      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= BK_IDLE;
      occ_q      <= '0;
      rd_idx_q   <= '0;
      s1_vld_q   <= 1'b0;
      hold_vld_q <= 1'b0;
      found_q    <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      occ_q      <= occ_d;
      rd_idx_q   <= rd_idx_d;
      s1_vld_q   <= s1_vld_d;
      hold_vld_q <= hold_vld_d;
      found_q    <= found_d;
      if (out_ld) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q       <= cmd_d;
    s1_idx_q    <= s1_idx_d;
    hold_idx_q  <= hold_idx_d;
    hold_tag_q  <= hold_tag_d;
    fin_reply_q <= fin_reply_d;
    fin_slot_q  <= fin_slot_d;
    fin_tag_q   <= fin_tag_d;
    if (out_ld) begin
      out_reply_q <= out_reply;
      out_slot_q  <= out_slot;
      out_tag_q   <= out_tag;
      out_last_q  <= out_last;
    end
  end

  // slot table, one write and one registered read a cycle
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata_q <= mem_q[rd_idx_q[IDX_W-1:0]];
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {4'd0, out_tag_q, out_slot_q};
  assign m_axis_tuser_o  = out_reply_q;
  assign m_axis_tlast_o  = out_last_q;

  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_vld_i && q_rdy_o) |-> (state_q == BK_IDLE))
    else $error("command taken while busy");

  a_hold_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hold_vld_q |-> (state_q == BK_WALK))
    else $error("held run outside a dispatch walk");

  a_write_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |-> ((state_q == BK_ADD) || (state_q == BK_WALK)))
    else $error("table write outside add or walk");

  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == BK_DONE) && out_free) |=> (out_vld_q && out_last_q))
    else $error("closing result not marked last");

endmodule

// ===== sv/periodic_task_scheduler.sv =====
// top level of the periodic task scheduler
// one command is carried out at a time; a two-entry queue accepts up to two ahead
// delete: decided when the command is taken, no walk; add: a free-slot walk over the occupancy bits
// tick and dispatch: a walk over all slots, one slot a cycle through the table read port
// output stalls add to the dispatch walk when a run waits behind an untaken result
// reset clears the occupancy bits and all control state at once; no clearing pass
module periodic_task_scheduler #(
  parameter int NUM_SLOTS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [87:0] s_axis_tdata_i,  // task_tag, start_delay, repeat_period, slot
  input  logic [1:0]  s_axis_tuser_i,  // kind
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,  // slot_out, tag_out, zero pad
  output logic [2:0]  m_axis_tuser_o,  // reply
  output logic        m_axis_tlast_o
);
  import pts_pkg::*;

  logic q_vld, q_rdy;
  cmd_t q_cmd;

  pts_front #(
    .NUM_SLOTS(NUM_SLOTS)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .q_vld_o        (q_vld),
    .q_rdy_i        (q_rdy),
    .q_cmd_o        (q_cmd)
  );

  pts_back #(
    .NUM_SLOTS(NUM_SLOTS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_vld_i        (q_vld),
    .q_rdy_o        (q_rdy),
    .q_cmd_i        (q_cmd),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

endmodule
